FILE: rtl/breakpoint_comparator_manager_defines.svh
// Assertion macros shared by the breakpoint comparator manager modules
`ifndef BREAKPOINT_COMPARATOR_MANAGER_DEFINES_SVH
`define BREAKPOINT_COMPARATOR_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define BCM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define BCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bcm_pkg.sv
// Types and constants of the breakpoint comparator manager
package bcm_pkg;

	// Operation codes
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} bcm_status_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_VERSION = 2'd0;
	localparam logic [1:0] CFG_COUNT   = 2'd1;
	localparam logic [1:0] CFG_ROM_LIM = 2'd2;

	// Configuration reset values
	localparam logic        VERSION_RST   = 1'b1;
	localparam logic [6:0]  COUNT_RST     = 7'd8;
	localparam logic [31:0] ROM_LIMIT_RST = 32'h2000_0000;

	// Comparator word fields
	localparam logic [31:0] ENC_MASK  = 32'hC000_0003;
	localparam logic [31:0] REMAP_HI  = 32'h8000_0000;
	localparam logic [31:0] REMAP_LO  = 32'h4000_0000;
	localparam logic [31:0] ENABLE_B  = 32'h0000_0001;
	localparam logic [31:0] HALF_B    = 32'h0000_0002;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic        in_ready;
		logic        scan_start;
		logic        scan_adv;
		logic        eval_en;
		logic        drop_hit;
		logic        write_slot;
		logic        clear_all;
		logic        emit_list;
		logic        emit_last;
		logic        load_resp;
		bcm_status_t resp_status;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic addr_bad;
		logic eval_ok;
		logic at_end;
		logic hit;
		logic found_any;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/bcm_if.sv
// Channel interfaces: request, result and configuration write

interface bcm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] address;

	modport source (output valid, operation, address, input ready);
	modport sink   (input valid, operation, address, output ready);
endinterface

interface bcm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [6:0]  entry_index;
	logic        entry_present;
	logic        decode_error;
	logic [31:0] listed_address;
	logic        last;

	modport source (output valid, status, entry_index, entry_present, decode_error,
		listed_address, last, input ready);
	modport sink   (input valid, status, entry_index, entry_present, decode_error,
		listed_address, last, output ready);
endinterface

interface bcm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/breakpoint_comparator_manager.sv
// Top level of the breakpoint comparator manager
//
// Channels: req takes one operation (add, remove, clear, list) with an address;
// rsp returns results; cfg writes the encoding version, comparator_count and rom_limit
// (index 0, 1, 2) and is always ready. Each transfer happens when valid and
// ready are both high at a rising clock edge.
// With n = min(comparator_count, NUM_COMPARATORS): clear and a rejected address go
// from the check straight to the result; add and remove scan the table one entry
// per cycle, and an add that finds no match writes the first free entry, if any,
// before its result. List gives its n results at one per cycle while the result
// register is free. The table is read one entry at a time through its registered
// read; one operation is worked at a time, and req is ready again the cycle after
// the final result is loaded into the output register.
// Reset clears all table entries at once through per-entry valid bits and
// restores the configuration defaults.
// A stalled rsp holds the result register; a list scan waits until the
// register is free, and the next request is still taken while the final
// result waits.
module breakpoint_comparator_manager #(
	parameter int unsigned NUM_COMPARATORS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	bcm_cfg_if.sink   cfg,
	bcm_req_if.sink   req,
	bcm_rsp_if.source rsp
);
	import bcm_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequencer
	bcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Table, compare and result path
	bcm_datapath #(
		.NUM_COMPARATORS (NUM_COMPARATORS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

FILE: rtl/bcm_datapath.sv
// Datapath: config registers, comparator table, scan stage and result register
`include "breakpoint_comparator_manager_defines.svh"

module bcm_datapath #(
	parameter int unsigned NUM_COMPARATORS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	bcm_cfg_if.sink           cfg,
	bcm_req_if.sink           req,
	bcm_rsp_if.source         rsp,
	input  bcm_pkg::ctl_cmd_t cmd,
	output bcm_pkg::dp_stat_t stat
);
	import bcm_pkg::*;

	localparam int unsigned IDX_W = (NUM_COMPARATORS > 1) ? $clog2(NUM_COMPARATORS) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_COMPARATORS + 1);

	logic        version_q;
	logic [6:0]  count_q;
	logic [31:0] rom_limit_q;
	logic [CNT_W-1:0] n_act;

	op_t         op_q;
	logic [31:0] addr_q;
	logic [31:0] enc;
	logic        addr_bad;

	logic [CNT_W-1:0] scan_q;
	logic [31:0] mem [NUM_COMPARATORS];
	logic [NUM_COMPARATORS-1:0] valid_q;
	logic [31:0] rd_word_s1;
	logic        rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic        found_q;
	logic [IDX_W-1:0] slot_q;

	logic [31:0] word;
	logic [31:0] dec;
	logic        dec_ok;
	logic        present;
	logic        derr;
	logic        free;

	logic        rsp_valid_q;
	bcm_status_t status_q;
	logic [6:0]  index_q;
	logic        present_q;
	logic        derr_q;
	logic [31:0] listed_q;
	logic        last_q;
	logic        out_free;

	// Configuration writes, always taken
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q   <= VERSION_RST;
			count_q     <= COUNT_RST;
			rom_limit_q <= ROM_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_VERSION: version_q   <= cfg.data[0];
				CFG_COUNT:   count_q     <= cfg.data[6:0];
				CFG_ROM_LIM: rom_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Comparators in use
	always_comb begin
		if (count_q >= 7'(NUM_COMPARATORS)) begin
			n_act = CNT_W'(NUM_COMPARATORS);
		end else begin
			n_act = count_q[CNT_W-1:0];
		end
	end

	// Request capture
	assign req.ready = cmd.in_ready;
	always_ff @(posedge clk) begin
		if (req.valid && cmd.in_ready) begin
			op_q   <= op_t'(req.operation);
			addr_q <= req.address;
		end
	end

	// Address check and comparator encoding
	assign addr_bad = addr_q[0] | (~version_q & (addr_q >= rom_limit_q));
	always_comb begin
		if (version_q) begin
			enc = addr_q | ENABLE_B;
		end else begin
			enc = (addr_q & ~ENC_MASK) | (addr_q[1] ? REMAP_HI : REMAP_LO) | ENABLE_B;
		end
	end

	// Scan counter: next entry to read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.scan_start) begin
			scan_q <= '0;
		end else if (cmd.scan_adv) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	// Table storage with registered read
	always_ff @(posedge clk) begin
		if (cmd.write_slot) begin
			mem[slot_q] <= enc;
		end
		if (cmd.scan_adv) begin
			rd_word_s1 <= mem[scan_q[IDX_W-1:0]];
			rd_vld_s1  <= valid_q[scan_q[IDX_W-1:0]];
			rd_idx_s1  <= scan_q[IDX_W-1:0];
		end
	end

	// Entry valid bits; an entry that is not valid reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.clear_all) begin
				for (int i = 0; i < NUM_COMPARATORS; i++) begin
					if (CNT_W'(i) < n_act) begin
						valid_q[i] <= 1'b0;
					end
				end
			end
			if (cmd.write_slot) begin
				valid_q[slot_q] <= 1'b1;
			end
			if (cmd.drop_hit) begin
				valid_q[rd_idx_s1] <= 1'b0;
			end
		end
	end

	// Compare stage on the entry just read
	assign word = rd_vld_s1 ? rd_word_s1 : '0;
	assign free = ~word[0];

	// First free entry seen during an add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			found_q <= 1'b0;
		end else if (cmd.eval_en && free) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_en && free && !found_q) begin
			slot_q <= rd_idx_s1;
		end
	end

	// Entry decode for list
	always_comb begin
		dec    = '0;
		dec_ok = 1'b0;
		if (!version_q) begin
			case (word[31:30])
				2'b01: begin
					dec    = word & ~ENC_MASK;
					dec_ok = 1'b1;
				end
				2'b10: begin
					dec    = (word & ~ENC_MASK) | HALF_B;
					dec_ok = 1'b1;
				end
				default: ;
			endcase
		end else if (word[0]) begin
			dec    = word & ~ENABLE_B;
			dec_ok = 1'b1;
		end
	end
	assign present = (word != '0) & dec_ok & (dec != '0);
	assign derr    = (word != '0) & ~dec_ok;

	// Result register
	assign out_free = ~rsp_valid_q | rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit_list || cmd.load_resp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_list) begin
			status_q  <= ST_OK;
			index_q   <= 7'(rd_idx_s1);
			present_q <= present;
			derr_q    <= derr;
			listed_q  <= present ? dec : '0;
			last_q    <= cmd.emit_last;
		end else if (cmd.load_resp) begin
			status_q  <= cmd.resp_status;
			index_q   <= '0;
			present_q <= 1'b0;
			derr_q    <= 1'b0;
			listed_q  <= '0;
			last_q    <= 1'b1;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.entry_index    = index_q;
	assign rsp.entry_present  = present_q;
	assign rsp.decode_error   = derr_q;
	assign rsp.listed_address = listed_q;
	assign rsp.last           = last_q;

	// Status to the controller
	always_comb begin
		stat.in_valid  = req.valid;
		stat.op        = op_q;
		stat.addr_bad  = addr_bad;
		stat.eval_ok   = (scan_q != '0);
		stat.at_end    = (scan_q == n_act);
		stat.hit       = (word == enc);
		stat.found_any = found_q | ((scan_q != '0) & free);
		stat.out_free  = out_free;
	end

	`BCM_ASSERT_IMPL(a_load_when_free, cmd.emit_list || cmd.load_resp, !rsp_valid_q || rsp.ready, "result register overwritten before transfer")
	`BCM_ASSERT_IMPL(a_write_has_slot, cmd.write_slot, found_q, "table write without a free entry")
	`BCM_ASSERT_IMPL(a_read_in_range, cmd.scan_adv, scan_q < n_act, "table read past comparators in use")

endmodule

FILE: rtl/bcm_ctrl.sv
// Controller: sequences check, table scan, write-back and result hand-off
`include "breakpoint_comparator_manager_defines.svh"

module bcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  bcm_pkg::dp_stat_t stat,
	output bcm_pkg::ctl_cmd_t cmd
);
	import bcm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_WRITE,
		S_RESP
	} state_t;

	state_t      state_q;
	state_t      state_d;
	bcm_status_t resp_q;
	bcm_status_t resp_d;
	logic        eval_hit;

	assign eval_hit = stat.eval_ok & stat.hit;

	// Commands and next state
	always_comb begin
		cmd             = '0;
		cmd.resp_status = resp_q;
		state_d         = state_q;
		resp_d          = resp_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.scan_start = 1'b1;
				case (stat.op) inside
					OP_ADD, OP_REMOVE: begin
						if (stat.addr_bad) begin
							resp_d  = ST_INVALID;
							state_d = S_RESP;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_CLEAR: begin
						cmd.clear_all = 1'b1;
						resp_d        = ST_OK;
						state_d       = S_RESP;
					end
					default: state_d = S_SCAN;
				endcase
			end
			S_SCAN: begin
				case (stat.op)
					OP_LIST: begin
						// hold the read stage while the result register is full
						if (!stat.eval_ok || stat.out_free) begin
							cmd.emit_list = stat.eval_ok;
							cmd.emit_last = stat.at_end;
							if (stat.at_end) begin
								state_d = S_IDLE;
							end else begin
								cmd.scan_adv = 1'b1;
							end
						end
					end
					OP_ADD: begin
						if (eval_hit) begin
							resp_d  = ST_OK;
							state_d = S_RESP;
						end else begin
							cmd.eval_en = stat.eval_ok;
							if (stat.at_end) begin
								if (stat.found_any) begin
									state_d = S_WRITE;
								end else begin
									resp_d  = ST_FULL;
									state_d = S_RESP;
								end
							end else begin
								cmd.scan_adv = 1'b1;
							end
						end
					end
					OP_REMOVE: begin
						if (eval_hit) begin
							cmd.drop_hit = 1'b1;
							resp_d       = ST_OK;
							state_d      = S_RESP;
						end else if (stat.at_end) begin
							resp_d  = ST_INVALID;
							state_d = S_RESP;
						end else begin
							cmd.scan_adv = 1'b1;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_WRITE: begin
				cmd.write_slot = 1'b1;
				resp_d         = ST_OK;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_resp = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and registered response code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			resp_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	`BCM_ASSERT_NEXT(a_write_then_ok, state_q == S_WRITE, state_q == S_RESP && resp_q == ST_OK, "write-back not followed by ok result")
	`BCM_ASSERT_NEXT(a_full_reported, state_q == S_SCAN && stat.op == OP_ADD && stat.at_end && !stat.found_any && !eval_hit, state_q == S_RESP && resp_q == ST_FULL, "full table not reported")
	`BCM_ASSERT_NEXT(a_bad_addr_rejected, state_q == S_CHECK && stat.addr_bad && (stat.op == OP_ADD || stat.op == OP_REMOVE), state_q == S_RESP && resp_q == ST_INVALID, "bad address not rejected")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the breakpoint comparator table manager
`timescale 1ns / 100ps

module testbench;
	import bcm_pkg::*;

	localparam int NUM_CMP      = 8;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int POOL_SIZE    = 12;
	// index past the last register, writes to it must change nothing
	localparam logic [1:0] CFG_NONE = 2'd3;

	// One result as the block returns it
	typedef struct packed {
		bcm_status_t status;
		logic [6:0]  idx;
		logic        present;
		logic        err;
		logic [31:0] addr;
		logic        last;
	} cmp_result_t;

	logic clk;
	logic arst_n;

	bcm_cfg_if cfg_ch();
	bcm_req_if req_ch();
	bcm_rsp_if rsp_ch();

	breakpoint_comparator_manager #(
		.NUM_COMPARATORS(NUM_CMP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Mirror of the comparator table and the registers
	logic [31:0] cmp_table [NUM_CMP];
	logic        fpb_ver;
	logic [6:0]  cmp_count;
	logic [31:0] rom_lim;

	cmp_result_t pending_results[$];

	int  mismatches   = 0;
	int  n_requests   = 0;
	int  n_results    = 0;
	int  n_cfg_writes = 0;
	int  n_list_err   = 0;
	int  hold_request = 0;
	bit  steady       = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Random idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic addr_legal(logic [31:0] a);
		if (a[0])
			return 1'b0;
		if (!fpb_ver && a >= rom_lim)
			return 1'b0;
		return 1'b1;
	endfunction

	// Comparator word for an address under the current encoding
	function automatic logic [31:0] cmp_word(logic [31:0] a);
		if (!fpb_ver)
			return (a & ~ENC_MASK) | (a[1] ? REMAP_HI : REMAP_LO) | ENABLE_B;
		return a | ENABLE_B;
	endfunction

	// Update the mirrored table for one operation and queue its results
	task automatic apply_table_op(input op_t op, input logic [31:0] a);
		int          n;
		int          slot;
		bit          hit;
		bit          free_seen;
		bit          ok;
		logic [31:0] word;
		logic [31:0] dec;
		cmp_result_t r;
		n = (int'(cmp_count) < NUM_CMP) ? int'(cmp_count) : NUM_CMP;
		r = '0;
		r.status = ST_OK;
		r.last = 1'b1;
		case (op)
			OP_ADD: begin
				if (!addr_legal(a)) begin
					r.status = ST_INVALID;
				end else begin
					word = cmp_word(a);
					hit = 1'b0;
					free_seen = 1'b0;
					slot = 0;
					for (int i = 0; i < n; i++) begin
						if (!free_seen && !cmp_table[i][0]) begin
							free_seen = 1'b1;
							slot = i;
						end
						if (cmp_table[i] == word)
							hit = 1'b1;
					end
					if (!hit && free_seen)
						cmp_table[slot] = word;
					else if (!hit)
						r.status = ST_FULL;
				end
				pending_results.push_back(r);
			end
			OP_REMOVE: begin
				r.status = ST_INVALID;
				if (addr_legal(a)) begin
					word = cmp_word(a);
					for (int i = 0; i < n; i++) begin
						if (r.status == ST_INVALID && cmp_table[i] == word) begin
							cmp_table[i] = '0;
							r.status = ST_OK;
						end
					end
				end
				pending_results.push_back(r);
			end
			OP_CLEAR: begin
				for (int i = 0; i < n; i++)
					cmp_table[i] = '0;
				pending_results.push_back(r);
			end
			default: begin
				// list: one decoded result per comparator in use
				for (int i = 0; i < n; i++) begin
					word = cmp_table[i];
					dec = '0;
					ok = 1'b0;
					if (!fpb_ver) begin
						if (word[31:30] == 2'b01) begin
							dec = word & ~ENC_MASK;
							ok = 1'b1;
						end else if (word[31:30] == 2'b10) begin
							dec = (word & ~ENC_MASK) | HALF_B;
							ok = 1'b1;
						end
					end else if (word[0]) begin
						dec = word & ~ENABLE_B;
						ok = 1'b1;
					end
					r = '0;
					r.status = ST_OK;
					r.idx = i[6:0];
					r.present = (word != '0) && ok && (dec != '0);
					r.err = (word != '0) && !ok;
					r.addr = r.present ? dec : '0;
					r.last = (i == n - 1);
					if (r.err)
						n_list_err++;
					pending_results.push_back(r);
				end
			end
		endcase
	endtask

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report($sformatf("result %0d %s got %0h expected %0h", n_results, name, got, want));
	endtask

	// Result checker: every transfer on rsp against the oldest expectation
	always @(posedge clk) begin : check_results
		cmp_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", n_results));
			end else begin
				want = pending_results.pop_front();
				check_field("status", rsp_ch.status, want.status);
				check_field("entry_index", rsp_ch.entry_index, want.idx);
				check_field("entry_present", rsp_ch.entry_present, want.present);
				check_field("decode_error", rsp_ch.decode_error, want.err);
				check_field("listed_address", rsp_ch.listed_address, want.addr);
				check_field("last", rsp_ch.last, want.last);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when a test asks for one
	initial begin : rsp_ready_drive
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results pending", cycles,
			pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Send one request; returns right after its transfer
	task automatic send_op(input op_t op, input logic [31:0] a);
		int gap;
		gap = steady ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			req_ch.operation = 2'($urandom);
			req_ch.address = $urandom;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.operation = op;
		req_ch.address = a;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		apply_table_op(op, a);
		n_requests++;
	endtask

	// Drop valid, wait for every result, then let the block settle
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_VERSION: fpb_ver = data[0];
			CFG_COUNT:   cmp_count = data[6:0];
			CFG_ROM_LIM: rom_lim = data;
			default: ;
		endcase
		n_cfg_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic test_reset_state();
		send_op(OP_LIST, '0);
	endtask

	// Version 2 encoding: duplicates, odd address, full table, remove
	task automatic test_version2_ops();
		cfg_write(CFG_COUNT, 32'd3);
		send_op(OP_ADD, 32'h0000_0000);
		send_op(OP_ADD, 32'hFFFF_FFFE);
		send_op(OP_ADD, 32'hFFFF_FFFE);
		send_op(OP_ADD, 32'h0000_0003);
		send_op(OP_ADD, 32'h0000_1000);
		send_op(OP_ADD, 32'h0000_2000);
		send_op(OP_REMOVE, 32'h0000_5554);
		send_op(OP_REMOVE, 32'h0000_0000);
		send_op(OP_LIST, '0);
	endtask

	// Version 1 encoding: ROM limit, remap halves, decode across encodings
	task automatic test_version1_ops();
		cfg_write(CFG_VERSION, 32'd0);
		cfg_write(CFG_COUNT, 32'd8);
		cfg_write(CFG_ROM_LIM, 32'h8000_0000);
		send_op(OP_LIST, '0);
		send_op(OP_ADD, 32'h8000_0000);
		send_op(OP_ADD, 32'h7FFF_FFFE);
		send_op(OP_ADD, 32'h0000_0000);
		send_op(OP_REMOVE, 32'h0000_1000);
		send_op(OP_LIST, '0);
		cfg_write(CFG_VERSION, 32'd1);
		send_op(OP_ADD, 32'hC000_0010);
		send_op(OP_LIST, '0);
		cfg_write(CFG_VERSION, 32'd0);
		send_op(OP_LIST, '0);
	endtask

	// Comparator count of zero, one and beyond the table
	task automatic test_count_extremes();
		cfg_write(CFG_COUNT, 32'd0);
		send_op(OP_ADD, 32'h0000_0100);
		send_op(OP_REMOVE, 32'h0000_0100);
		send_op(OP_CLEAR, '0);
		send_op(OP_LIST, '0);
		cfg_write(CFG_NONE, 32'hFFFF_FFFF);
		cfg_write(CFG_COUNT, 32'd127);
		send_op(OP_CLEAR, '0);
		send_op(OP_ADD, 32'h0000_0200);
		cfg_write(CFG_COUNT, 32'd1);
		send_op(OP_ADD, 32'h0000_0300);
		send_op(OP_LIST, '0);
	endtask

	// Receiver holds off while requests keep coming
	task automatic test_backpressure();
		cfg_write(CFG_VERSION, 32'd1);
		cfg_write(CFG_COUNT, 32'd8);
		hold_request = 300;
		send_op(OP_LIST, '0);
		send_op(OP_ADD, 32'h0000_4000);
		send_op(OP_LIST, '0);
		send_op(OP_REMOVE, 32'h0000_4000);
		send_op(OP_ADD, 32'h1234_5678);
		send_op(OP_LIST, '0);
	endtask

	// One random phase: set the registers, then a mix drawn from an address pool
	task automatic random_phase(input logic ver, input logic [6:0] cnt,
		input logic [31:0] rom, input int items, input bit calm);
		logic [31:0] addr_pool [POOL_SIZE];
		logic [31:0] a;
		int          r;
		cfg_write(CFG_VERSION, {31'd0, ver});
		cfg_write(CFG_COUNT, {25'd0, cnt});
		cfg_write(CFG_ROM_LIM, rom);
		for (int i = 0; i < POOL_SIZE; i++) begin
			a = $urandom;
			if (!ver && rom != '0)
				a = a % rom;
			a[0] = 1'b0;
			addr_pool[i] = a;
		end
		steady = calm;
		for (int k = 0; k < items; k++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 85)
				a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				a = $urandom;
			if (r < 45)
				send_op(OP_ADD, a);
			else if (r < 78)
				send_op(OP_REMOVE, a);
			else if (r < 82)
				send_op(OP_CLEAR, a);
			else
				send_op(OP_LIST, a);
		end
		wait_idle();
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		random_phase(1'b1, 7'd8, ROM_LIMIT_RST, 90, 1'b0);
		random_phase(1'b0, 7'd8, 32'hFFFF_FFFF, 90, 1'b0);
		random_phase(1'b0, 7'd5, ROM_LIMIT_RST, 70, 1'b0);
		random_phase(1'b1, 7'd127, ROM_LIMIT_RST, 60, 1'b1);
		random_phase(1'b0, 7'd2, 32'h0001_0000, 60, 1'b0);
		random_phase(1'b0, 7'd8, 32'h0000_0000, 20, 1'b0);
	endtask

	// Main sequence
	initial begin
		for (int i = 0; i < NUM_CMP; i++)
			cmp_table[i] = '0;
		fpb_ver = VERSION_RST;
		cmp_count = COUNT_RST;
		rom_lim = ROM_LIMIT_RST;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ADD;
		req_ch.address = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_VERSION;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_version2_ops();
		test_version1_ops();
		test_count_extremes();
		test_backpressure();
		test_random_traffic();
		wait_idle();

		$display("Covered %0d requests and %0d results (%0d listed decode errors),",
			n_requests, n_results, n_list_err);
		$display("%0d register writes: both encodings, counts 0 to 127, ROM limits 0 to max.",
			n_cfg_writes);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/bcm_pkg.sv
rtl/bcm_if.sv
rtl/bcm_datapath.sv
rtl/bcm_ctrl.sv
rtl/breakpoint_comparator_manager.sv
verif/testbench.sv
